/* hdl/bba_pkg.sv */
package bba_pkg;

    localparam int POOL_ORDER = 16;
    localparam int MIN_ORDER  = 5;
    localparam int UNIT_BITS  = POOL_ORDER - MIN_ORDER;
    localparam int NODE_BITS  = UNIT_BITS + 1;
    localparam int WORD_BITS  = 6;
    localparam int WORD_W     = 1 << WORD_BITS;
    localparam int FM_ADDR_W  = NODE_BITS - WORD_BITS;
    localparam int LEVELS     = POOL_ORDER - MIN_ORDER + 1;
    localparam int UM_DATA_W  = 6;
    localparam int unsigned POOL_BYTES = 32'd1 << POOL_ORDER;

    localparam logic [6:0] HEADER_RESET = 7'd24;

    typedef logic [POOL_ORDER-1:0] t_addr;
    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [WORD_W-1:0]     t_word;
    typedef logic [FM_ADDR_W-1:0]  t_waddr;
    typedef logic [UNIT_BITS-1:0]  t_unit;
    typedef logic [4:0]            t_ord;
    typedef logic [24:0]           t_need;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    localparam logic [1:0] REG_HEADER = 2'd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_PICK,
        S_A_LVL,
        S_A_RD,
        S_A_CHK,
        S_A_SPL,
        S_A_SPW,
        S_A_REC,
        S_F_LOOK,
        S_F_UNIT,
        S_F_RD,
        S_F_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic inc;
        logic dec;
        t_ord order;
    } t_cnt_upd;

    // tree node of the block of the given order at start
    function automatic t_node node_of(input t_addr start, input t_ord order);
        logic [POOL_ORDER:0] v;
        v = {1'b1, start} >> order;
        return t_node'(v);
    endfunction

    // smallest order that holds need bytes, raised to the minimum order
    function automatic t_ord ceil_order(input t_need need);
        t_ord k;
        k = t_ord'(POOL_ORDER);
        for (int i = POOL_ORDER; i >= 0; i--) begin
            if (32'(need) <= (32'd1 << i)) begin
                k = t_ord'(i);
            end
        end
        if (k < t_ord'(MIN_ORDER)) begin
            k = t_ord'(MIN_ORDER);
        end
        return k;
    endfunction

endpackage

/* hdl/bba_ram.sv */
module bba_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hdl/bba_level_cnt.sv */
module bba_level_cnt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bba_pkg::t_cnt_upd            i_upd,
    output logic [bba_pkg::LEVELS-1:0]   o_nonempty
);

    logic [bba_pkg::NODE_BITS-1:0] r_cnt [bba_pkg::LEVELS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < bba_pkg::LEVELS; i++) begin
            if (!i_rst_n) begin
                r_cnt[i] <= (i == bba_pkg::LEVELS - 1) ? bba_pkg::NODE_BITS'(1) : '0;
            end else if (i_upd.order == bba_pkg::t_ord'(i + bba_pkg::MIN_ORDER)) begin
                if (i_upd.inc) begin
                    r_cnt[i] <= r_cnt[i] + bba_pkg::NODE_BITS'(1);
                end else if (i_upd.dec) begin
                    r_cnt[i] <= r_cnt[i] - bba_pkg::NODE_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < bba_pkg::LEVELS; i++) begin
            o_nonempty[i] = (r_cnt[i] != '0);
        end
    end

endmodule

/* hdl/buddy_block_allocator.sv */
// Channel  Direction  Handshake                  Payload
// in       to block   i_in_valid / o_in_stall    i_operation, i_request_bytes, i_release_address
// out      from block o_out_valid / i_out_stall  o_granted_address, o_status
// cfg      to block   psel/penable/pwrite/pready paddr, pwdata, prdata (header_bytes at 0)
//
// After reset a clearing pass sweeps both memories; no item is taken then.
// Allocate walks the free bitmap memory one 64-node word per access, then splits down to
// the needed order; free merges with each free buddy up the tree; a refusal or an
// invalid free ends without an access to the free bitmap memory.
// One item is in work at a time; the result register lets the next item enter while
// a finished result is stalled at the output.
module buddy_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [23:0] i_request_bytes,
    input  logic [15:0] i_release_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_granted_address,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bba_pkg::t_state r_state, n_state;

    logic                    r_op;
    logic [23:0]             r_req;
    logic [15:0]             r_rel;
    logic [6:0]              r_hdr;
    bba_pkg::t_ord           r_k, n_k;
    bba_pkg::t_ord           r_j, n_j;
    bba_pkg::t_waddr         r_w, n_w;
    bba_pkg::t_addr          r_start, n_start;
    bba_pkg::t_unit          r_clr;
    logic [15:0]             r_res_addr, n_res_addr;
    logic [1:0]              r_res_status, n_res_status;
    logic                    r_out_valid;
    logic [15:0]             r_out_addr;
    logic [1:0]              r_out_status;

    logic                    fm_we, fm_re;
    bba_pkg::t_waddr         fm_waddr, fm_raddr;
    bba_pkg::t_word          fm_wdata, fm_rdata;
    logic                    um_we, um_re;
    bba_pkg::t_unit          um_waddr, um_raddr;
    logic [bba_pkg::UM_DATA_W-1:0] um_wdata, um_rdata;

    bba_pkg::t_cnt_upd       cnt_upd;
    logic [bba_pkg::LEVELS-1:0] nonempty;

    bba_pkg::t_need          need;
    logic                    too_big;
    bba_pkg::t_ord           k_need;
    logic                    lvl_found;
    bba_pkg::t_ord           lvl_pick;
    bba_pkg::t_node          base;
    bba_pkg::t_word          masked;
    logic [bba_pkg::WORD_BITS-1:0] hit_pos;
    bba_pkg::t_node          hit_node;
    bba_pkg::t_node          own_node;
    bba_pkg::t_node          buddy_node;
    bba_pkg::t_ord           spl_j;
    bba_pkg::t_node          spl_node;
    logic [15:0]             rel_start;
    logic                    rel_bad;
    bba_pkg::t_ord           unit_order;
    logic                    out_free;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == bba_pkg::REG_HEADER) ? {25'd0, r_hdr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= bba_pkg::HEADER_RESET;
        end else if (psel && penable && pwrite && pready && paddr == bba_pkg::REG_HEADER) begin
            r_hdr <= pwdata[6:0];
        end
    end

    bba_ram #(
        .DATA_W (bba_pkg::WORD_W),
        .ADDR_W (bba_pkg::FM_ADDR_W)
    ) u_free_map (
        .i_clk   (i_clk),
        .i_we    (fm_we),
        .i_waddr (fm_waddr),
        .i_wdata (fm_wdata),
        .i_re    (fm_re),
        .i_raddr (fm_raddr),
        .o_rdata (fm_rdata)
    );

    bba_ram #(
        .DATA_W (bba_pkg::UM_DATA_W),
        .ADDR_W (bba_pkg::UNIT_BITS)
    ) u_unit_map (
        .i_clk   (i_clk),
        .i_we    (um_we),
        .i_waddr (um_waddr),
        .i_wdata (um_wdata),
        .i_re    (um_re),
        .i_raddr (um_raddr),
        .o_rdata (um_rdata)
    );

    bba_level_cnt u_level_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (cnt_upd),
        .o_nonempty (nonempty)
    );

    // datapath helpers
    assign need    = {1'b0, r_req} + bba_pkg::t_need'(r_hdr);
    assign too_big = 32'(need) > bba_pkg::POOL_BYTES;
    assign k_need  = bba_pkg::ceil_order(need);

    always_comb begin
        lvl_found = 1'b0;
        lvl_pick  = r_k;
        for (int i = bba_pkg::POOL_ORDER; i >= bba_pkg::MIN_ORDER; i--) begin
            if (bba_pkg::t_ord'(i) >= r_k && nonempty[i - bba_pkg::MIN_ORDER]) begin
                lvl_found = 1'b1;
                lvl_pick  = bba_pkg::t_ord'(i);
            end
        end
    end

    assign base = bba_pkg::t_node'(1) << (bba_pkg::t_ord'(bba_pkg::POOL_ORDER) - r_j);

    // keep only the nodes of the level being searched
    always_comb begin
        bba_pkg::t_node nd;
        for (int b = 0; b < bba_pkg::WORD_W; b++) begin
            nd = {r_w, bba_pkg::WORD_BITS'(b)};
            masked[b] = fm_rdata[b] && nd >= base && {1'b0, nd} < {base, 1'b0};
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
            if (masked[b]) begin
                hit_pos = bba_pkg::WORD_BITS'(b);
            end
        end
    end

    assign hit_node   = {r_w, hit_pos};
    assign own_node   = bba_pkg::node_of(r_start, r_k);
    assign buddy_node = own_node ^ bba_pkg::t_node'(1);
    assign spl_j      = (r_state == bba_pkg::S_A_SPL) ? r_j - bba_pkg::t_ord'(1) : r_j;
    assign spl_node   = bba_pkg::node_of(r_start | (bba_pkg::t_addr'(1) << spl_j), spl_j);

    assign rel_start = r_rel - 16'(r_hdr);
    assign rel_bad   = (r_rel < 16'(r_hdr)) || (32'(rel_start) >= bba_pkg::POOL_BYTES)
                       || (rel_start[bba_pkg::MIN_ORDER-1:0] != '0);

    always_comb begin
        unit_order = um_rdata[4:0];
        if (unit_order < bba_pkg::t_ord'(bba_pkg::MIN_ORDER)
                || unit_order > bba_pkg::t_ord'(bba_pkg::POOL_ORDER)) begin
            unit_order = bba_pkg::t_ord'(bba_pkg::MIN_ORDER);
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != bba_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bba_pkg::S_CLEAR) begin
                r_clr <= r_clr + bba_pkg::t_unit'(1);
            end
            if (r_state == bba_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op  <= i_operation;
            r_req <= i_request_bytes;
            r_rel <= i_release_address;
        end
        r_k          <= n_k;
        r_j          <= n_j;
        r_w          <= n_w;
        r_start      <= n_start;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (r_state == bba_pkg::S_DONE && out_free) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_j          = r_j;
        n_w          = r_w;
        n_start      = r_start;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        fm_we        = 1'b0;
        fm_waddr     = own_node[bba_pkg::NODE_BITS-1 -: bba_pkg::FM_ADDR_W];
        fm_wdata     = fm_rdata;
        fm_re        = 1'b0;
        fm_raddr     = own_node[bba_pkg::NODE_BITS-1 -: bba_pkg::FM_ADDR_W];
        um_we        = 1'b0;
        um_waddr     = bba_pkg::t_unit'(r_start >> bba_pkg::MIN_ORDER);
        um_wdata     = {1'b1, r_k};
        um_re        = 1'b0;
        um_raddr     = bba_pkg::t_unit'(rel_start >> bba_pkg::MIN_ORDER);
        cnt_upd      = '{inc: 1'b0, dec: 1'b0, order: r_k};

        unique case (r_state)
            bba_pkg::S_CLEAR: begin
                um_we    = 1'b1;
                um_waddr = r_clr;
                um_wdata = '0;
                if (r_clr < bba_pkg::t_unit'(2 ** bba_pkg::FM_ADDR_W)) begin
                    fm_we    = 1'b1;
                    fm_waddr = bba_pkg::t_waddr'(r_clr);
                    // whole pool is node 1
                    fm_wdata = (r_clr == '0) ? bba_pkg::t_word'(2) : '0;
                end
                if (r_clr == '1) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_operation == bba_pkg::OP_FREE) ? bba_pkg::S_F_LOOK
                                                                 : bba_pkg::S_A_PICK;
                end
            end
            bba_pkg::S_A_PICK: begin
                n_res_addr = '0;
                if (r_req == '0 || too_big) begin
                    n_res_status = bba_pkg::ST_REFUSED;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    n_k     = k_need;
                    n_state = bba_pkg::S_A_LVL;
                end
            end
            bba_pkg::S_A_LVL: begin
                if (!lvl_found) begin
                    n_res_status = bba_pkg::ST_REFUSED;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    n_j     = lvl_pick;
                    n_w     = bba_pkg::t_waddr'((bba_pkg::t_node'(1)
                              << (bba_pkg::t_ord'(bba_pkg::POOL_ORDER) - lvl_pick))
                              >> bba_pkg::WORD_BITS);
                    n_state = bba_pkg::S_A_RD;
                end
            end
            bba_pkg::S_A_RD: begin
                fm_re    = 1'b1;
                fm_raddr = r_w;
                n_state  = bba_pkg::S_A_CHK;
            end
            bba_pkg::S_A_CHK: begin
                if (masked != '0) begin
                    fm_we    = 1'b1;
                    fm_waddr = r_w;
                    fm_wdata = fm_rdata & ~(bba_pkg::t_word'(1) << hit_pos);
                    cnt_upd  = '{inc: 1'b0, dec: 1'b1, order: r_j};
                    n_start  = bba_pkg::t_addr'(32'(hit_node ^ base) << r_j);
                    n_state  = (r_j == r_k) ? bba_pkg::S_A_REC : bba_pkg::S_A_SPL;
                end else begin
                    // the level count says a free node lies further on
                    n_w     = r_w + bba_pkg::t_waddr'(1);
                    n_state = bba_pkg::S_A_RD;
                end
            end
            bba_pkg::S_A_SPL: begin
                fm_re    = 1'b1;
                fm_raddr = spl_node[bba_pkg::NODE_BITS-1 -: bba_pkg::FM_ADDR_W];
                n_j      = spl_j;
                n_state  = bba_pkg::S_A_SPW;
            end
            bba_pkg::S_A_SPW: begin
                // upper half of the split becomes free
                fm_we    = 1'b1;
                fm_waddr = spl_node[bba_pkg::NODE_BITS-1 -: bba_pkg::FM_ADDR_W];
                fm_wdata = fm_rdata
                           | (bba_pkg::t_word'(1) << spl_node[bba_pkg::WORD_BITS-1:0]);
                cnt_upd  = '{inc: 1'b1, dec: 1'b0, order: r_j};
                n_state  = (r_j == r_k) ? bba_pkg::S_A_REC : bba_pkg::S_A_SPL;
            end
            bba_pkg::S_A_REC: begin
                um_we        = 1'b1;
                n_res_addr   = 16'(32'(r_start) + 32'(r_hdr));
                n_res_status = bba_pkg::ST_DONE;
                n_state      = bba_pkg::S_DONE;
            end
            bba_pkg::S_F_LOOK: begin
                n_res_addr = '0;
                if (rel_bad) begin
                    n_res_status = bba_pkg::ST_BAD;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    um_re   = 1'b1;
                    n_start = bba_pkg::t_addr'(rel_start);
                    n_state = bba_pkg::S_F_UNIT;
                end
            end
            bba_pkg::S_F_UNIT: begin
                if (!um_rdata[bba_pkg::UM_DATA_W-1]) begin
                    n_res_status = bba_pkg::ST_BAD;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    um_we    = 1'b1;
                    um_wdata = '0;
                    n_k      = unit_order;
                    n_state  = bba_pkg::S_F_RD;
                end
            end
            bba_pkg::S_F_RD: begin
                // own node and its buddy share one word
                fm_re   = 1'b1;
                n_state = bba_pkg::S_F_CHK;
            end
            bba_pkg::S_F_CHK: begin
                fm_we = 1'b1;
                if (r_k < bba_pkg::t_ord'(bba_pkg::POOL_ORDER)
                        && fm_rdata[buddy_node[bba_pkg::WORD_BITS-1:0]]) begin
                    fm_wdata = fm_rdata
                               & ~(bba_pkg::t_word'(1) << buddy_node[bba_pkg::WORD_BITS-1:0]);
                    cnt_upd  = '{inc: 1'b0, dec: 1'b1, order: r_k};
                    n_start  = r_start & ~(bba_pkg::t_addr'(1) << r_k);
                    n_k      = r_k + bba_pkg::t_ord'(1);
                    n_state  = bba_pkg::S_F_RD;
                end else begin
                    fm_wdata     = fm_rdata
                                   | (bba_pkg::t_word'(1) << own_node[bba_pkg::WORD_BITS-1:0]);
                    cnt_upd      = '{inc: 1'b1, dec: 1'b0, order: r_k};
                    n_res_status = bba_pkg::ST_DONE;
                    n_state      = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_status          = r_out_status;

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != bba_pkg::ST_DONE |-> o_granted_address == '0)
        else $error("refused item carries an address");

    a_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bba_pkg::S_DONE && r_op == bba_pkg::OP_FREE |-> r_res_addr == '0)
        else $error("free result carries an address");

    a_cnt_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cnt_upd.inc && cnt_upd.dec))
        else $error("level count raised and lowered together");

    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> r_state == bba_pkg::S_CLEAR && o_in_stall)
        else $error("clearing pass skipped after reset");

endmodule
